// File: hdl/sph_alpha_factor_defines.svh
// ----------------------------------------------------------------------------
// sph_alpha_factor_defines
// Assertion macros shared by the checker of the alpha factor block.
// ----------------------------------------------------------------------------
`ifndef SPH_ALPHA_FACTOR_DEFINES_SVH
`define SPH_ALPHA_FACTOR_DEFINES_SVH

// Property checked on every clock edge while reset is low.
`define SAF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SAF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/saf_pkg.sv
// ----------------------------------------------------------------------------
// saf_pkg
// Widths, codes and controller interface types of the alpha factor block.
// ----------------------------------------------------------------------------
`default_nettype none

package saf_pkg;

  localparam int WORD_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_WIDTH   = 31;
  localparam int MODE_WIDTH  = 2;
  localparam int IDX_WIDTH   = 1;
  localparam int FLAG_WIDTH  = 2;
  localparam int SUM_WIDTH   = 48;
  localparam int MSQ_WIDTH   = 64;
  localparam int OPD_WIDTH   = 48;
  localparam int CHUNK_WIDTH = 16;
  localparam int CHUNK_COUNT = OPD_WIDTH / CHUNK_WIDTH;
  localparam int PROD_WIDTH  = 2 * OPD_WIDTH;
  localparam int DVD_WIDTH   = CFG_WIDTH + FRAC_BITS;

  localparam int IN_DATA_WIDTH = 128;
  localparam int GX_LSB        = 0;
  localparam int GY_LSB        = GX_LSB + WORD_WIDTH;
  localparam int VOL_LSB       = GY_LSB + WORD_WIDTH;
  localparam int DENS_LSB      = VOL_LSB + CFG_WIDTH;

  localparam logic [CFG_WIDTH-1:0] MASS_RESET  = 31'd65536;
  localparam logic [CFG_WIDTH-1:0] TDENS_RESET = 31'd65536000;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_FLUID = 2'd0,
    MODE_SOLID = 2'd1,
    MODE_EMPTY = 2'd2
  } mode_t;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_MASS  = 1'b0,
    REG_TDENS = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_SQX,
    ST_SQY,
    ST_VD,
    ST_VX,
    ST_VY,
    ST_FX,
    ST_FY,
    ST_DIV,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MX,
    OP_MY,
    OP_SQX,
    OP_SQY,
    OP_VD,
    OP_VX,
    OP_VY,
    OP_FX,
    OP_FY
  } mul_op_t;

  typedef struct packed {
    logic    load_item;
    logic    mul_start;
    logic    mul_wb;
    mul_op_t op;
    logic    div_start;
    logic    out_write;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic out_free;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/saf_mul.sv
// ----------------------------------------------------------------------------
// saf_mul
// Unsigned 48x48 multiplier, one 16-bit chunk of b per cycle, result scaled
// down by the fraction bits and saturated to 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module saf_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [saf_pkg::OPD_WIDTH-1:0] a,
  input  logic [saf_pkg::OPD_WIDTH-1:0] b,
  output logic                          done,
  output logic [saf_pkg::MSQ_WIDTH-1:0] result
);
  import saf_pkg::*;

  localparam int CNT_WIDTH = $clog2(CHUNK_COUNT);
  localparam int PART_WIDTH = OPD_WIDTH + CHUNK_WIDTH;

  logic                   busy;
  logic [CNT_WIDTH-1:0]   cnt;
  logic [OPD_WIDTH-1:0]   a_r;
  logic [OPD_WIDTH-1:0]   b_r;
  logic [PROD_WIDTH-1:0]  acc;
  logic [CHUNK_WIDTH-1:0] chunk;
  logic [PART_WIDTH-1:0]  partial;
  logic [PROD_WIDTH-1:0]  acc_next;

  assign chunk    = b_r[cnt*CHUNK_WIDTH +: CHUNK_WIDTH];
  assign partial  = PART_WIDTH'(a_r) * PART_WIDTH'(chunk);
  assign acc_next = {acc[PROD_WIDTH-CHUNK_WIDTH-1:0], {CHUNK_WIDTH{1'b0}}}
                  + PROD_WIDTH'(partial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_WIDTH'(CHUNK_COUNT - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
    end
  end

  assign result = (|acc[PROD_WIDTH-1:MSQ_WIDTH+FRAC_BITS]) ? {MSQ_WIDTH{1'b1}}
                : acc[MSQ_WIDTH+FRAC_BITS-1:FRAC_BITS];

endmodule

`default_nettype wire

// File: hdl/saf_div.sv
// ----------------------------------------------------------------------------
// saf_div
// Restoring divider, one quotient bit per cycle, 47-bit dividend over a
// 64-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module saf_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [saf_pkg::DVD_WIDTH-1:0] dividend,
  input  logic [saf_pkg::MSQ_WIDTH-1:0] divisor,
  output logic                          done,
  output logic [saf_pkg::DVD_WIDTH-1:0] quotient
);
  import saf_pkg::*;

  localparam int CNT_WIDTH = $clog2(DVD_WIDTH);

  logic                 busy;
  logic [CNT_WIDTH-1:0] cnt;
  logic [MSQ_WIDTH-1:0] rem;
  logic [MSQ_WIDTH-1:0] dsr;
  logic [DVD_WIDTH-1:0] dvd;
  logic [MSQ_WIDTH:0]   trial;
  logic [MSQ_WIDTH:0]   diff;
  logic                 ge;

  assign trial = {rem, dvd[DVD_WIDTH-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_WIDTH'(DVD_WIDTH - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      dvd      <= dividend;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[MSQ_WIDTH-1:0] : trial[MSQ_WIDTH-1:0];
      dvd      <= {dvd[DVD_WIDTH-2:0], 1'b0};
      quotient <= {quotient[DVD_WIDTH-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: hdl/saf_ctrl.sv
// ----------------------------------------------------------------------------
// saf_ctrl
// Sequencer that walks one neighbor contribution, and on the last neighbor
// the final squares and division, through the shared datapath units.
// ----------------------------------------------------------------------------
`default_nettype none

module saf_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [saf_pkg::MODE_WIDTH-1:0] in_mode,
  input  logic                           in_last,
  output logic                           in_ready,
  output saf_pkg::dp_cmd_t               cmd,
  input  saf_pkg::dp_status_t            status
);
  import saf_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  ctrl_state_t follow;
  mul_op_t     op;
  logic        issued;
  logic        issued_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  always_comb begin
    op     = OP_NONE;
    follow = ST_IDLE;
    case (state)
      ST_MX: begin
        op     = OP_MX;
        follow = ST_MY;
      end
      ST_MY: begin
        op     = OP_MY;
        follow = ST_SQX;
      end
      ST_SQX: begin
        op     = OP_SQX;
        follow = ST_SQY;
      end
      ST_SQY: begin
        op     = OP_SQY;
        follow = status.last ? ST_FX : ST_IDLE;
      end
      ST_VD: begin
        op     = OP_VD;
        follow = ST_VX;
      end
      ST_VX: begin
        op     = OP_VX;
        follow = ST_VY;
      end
      ST_VY: begin
        op     = OP_VY;
        follow = status.last ? ST_FX : ST_IDLE;
      end
      ST_FX: begin
        op     = OP_FX;
        follow = ST_FY;
      end
      ST_FY: begin
        op     = OP_FY;
        follow = ST_DIV;
      end
      default: begin
        op     = OP_NONE;
        follow = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    issued_next = issued;
    in_ready = 1'b0;
    cmd = '0;
    cmd.op = op;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (mode_t'(in_mode))
            MODE_FLUID: state_next = ST_MX;
            MODE_SOLID: state_next = ST_VD;
            default:    state_next = in_last ? ST_FX : ST_IDLE;
          endcase
        end
      end
      ST_MX, ST_MY, ST_SQX, ST_SQY, ST_VD, ST_VX, ST_VY, ST_FX, ST_FY: begin
        if (!issued) begin
          cmd.mul_start = 1'b1;
          issued_next = 1'b1;
        end else if (status.mul_done) begin
          cmd.mul_wb = 1'b1;
          issued_next = 1'b0;
          state_next = follow;
        end
      end
      ST_DIV: begin
        if (!issued) begin
          cmd.div_start = 1'b1;
          issued_next = 1'b1;
        end else if (status.div_done) begin
          issued_next = 1'b0;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_write = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        issued_next = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/saf_dp.sv
// ----------------------------------------------------------------------------
// saf_dp
// Datapath: configuration and item registers, vector and scalar sums, the
// shared multiplier, the divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module saf_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [saf_pkg::IDX_WIDTH-1:0]  cfg_index,
  input  logic [saf_pkg::CFG_WIDTH-1:0]  cfg_data,
  input  logic [saf_pkg::WORD_WIDTH-1:0] grad_x,
  input  logic [saf_pkg::WORD_WIDTH-1:0] grad_y,
  input  logic [saf_pkg::CFG_WIDTH-1:0]  solid_volume,
  input  logic [saf_pkg::CFG_WIDTH-1:0]  particle_density,
  input  logic                           last_neighbor,
  input  saf_pkg::dp_cmd_t               cmd,
  output saf_pkg::dp_status_t            status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [saf_pkg::WORD_WIDTH-1:0] alpha,
  output logic                           denom_was_zero,
  output logic                           saturated
);
  import saf_pkg::*;

  localparam logic [SUM_WIDTH-1:0] NEG_LIMIT = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic [SUM_WIDTH-1:0] POS_LIMIT = {1'b0, {(SUM_WIDTH-1){1'b1}}};

  function automatic logic [SUM_WIDTH-1:0] clamp_mag(input logic neg,
                                                     input logic [MSQ_WIDTH-1:0] mag);
    logic [MSQ_WIDTH-1:0] lim;
    lim = neg ? MSQ_WIDTH'(NEG_LIMIT) : MSQ_WIDTH'(POS_LIMIT);
    return (mag > lim) ? lim[SUM_WIDTH-1:0] : mag[SUM_WIDTH-1:0];
  endfunction

  function automatic logic [SUM_WIDTH-1:0] add_term(input logic [SUM_WIDTH-1:0] s,
                                                    input logic neg,
                                                    input logic [MSQ_WIDTH-1:0] mag);
    logic [SUM_WIDTH-1:0] cm;
    logic [SUM_WIDTH-1:0] t;
    logic [SUM_WIDTH:0]   r;
    cm = clamp_mag(neg, mag);
    t  = neg ? (~cm + 1'b1) : cm;
    r  = {s[SUM_WIDTH-1], s} + {t[SUM_WIDTH-1], t};
    if (r[SUM_WIDTH] != r[SUM_WIDTH-1]) begin
      return r[SUM_WIDTH] ? NEG_LIMIT : POS_LIMIT;
    end
    return r[SUM_WIDTH-1:0];
  endfunction

  function automatic logic [MSQ_WIDTH-1:0] add_sat(input logic [MSQ_WIDTH-1:0] x,
                                                   input logic [MSQ_WIDTH-1:0] y);
    logic [MSQ_WIDTH:0] r;
    r = {1'b0, x} + {1'b0, y};
    return r[MSQ_WIDTH] ? {MSQ_WIDTH{1'b1}} : r[MSQ_WIDTH-1:0];
  endfunction

  logic [CFG_WIDTH-1:0]  mass;
  logic [CFG_WIDTH-1:0]  tdens;
  logic                  nx;
  logic                  ny;
  logic [WORD_WIDTH-1:0] gx_mag;
  logic [WORD_WIDTH-1:0] gy_mag;
  logic [CFG_WIDTH-1:0]  vol;
  logic [CFG_WIDTH-1:0]  dens;
  logic                  last;
  logic [SUM_WIDTH-1:0]  sum_x;
  logic [SUM_WIDTH-1:0]  sum_y;
  logic [MSQ_WIDTH-1:0]  msq;
  logic [SUM_WIDTH-1:0]  tmag_x;
  logic [SUM_WIDTH-1:0]  tmag_y;
  logic [SUM_WIDTH-1:0]  vd;
  logic [MSQ_WIDTH-1:0]  sq;
  logic [MSQ_WIDTH-1:0]  den;
  logic [SUM_WIDTH-1:0]  sx_abs;
  logic [SUM_WIDTH-1:0]  sy_abs;
  logic [OPD_WIDTH-1:0]  opd_a;
  logic [OPD_WIDTH-1:0]  opd_b;
  logic                  mul_done;
  logic [MSQ_WIDTH-1:0]  mul_res;
  logic                  div_done;
  logic [DVD_WIDTH-1:0]  quo;
  logic                  over;
  logic                  is_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass  <= MASS_RESET;
      tdens <= TDENS_RESET;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_MASS:  mass  <= cfg_data;
        REG_TDENS: tdens <= cfg_data;
        default:   mass  <= mass;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      nx     <= grad_x[WORD_WIDTH-1];
      ny     <= grad_y[WORD_WIDTH-1];
      gx_mag <= grad_x[WORD_WIDTH-1] ? (~grad_x + 1'b1) : grad_x;
      gy_mag <= grad_y[WORD_WIDTH-1] ? (~grad_y + 1'b1) : grad_y;
      vol    <= solid_volume;
      dens   <= particle_density;
      last   <= last_neighbor;
    end
  end

  assign sx_abs = sum_x[SUM_WIDTH-1] ? (~sum_x + 1'b1) : sum_x;
  assign sy_abs = sum_y[SUM_WIDTH-1] ? (~sum_y + 1'b1) : sum_y;

  always_comb begin
    case (cmd.op)
      OP_MX: begin
        opd_a = OPD_WIDTH'(mass);
        opd_b = OPD_WIDTH'(gx_mag);
      end
      OP_MY: begin
        opd_a = OPD_WIDTH'(mass);
        opd_b = OPD_WIDTH'(gy_mag);
      end
      OP_SQX: begin
        opd_a = tmag_x;
        opd_b = tmag_x;
      end
      OP_SQY: begin
        opd_a = tmag_y;
        opd_b = tmag_y;
      end
      OP_VD: begin
        opd_a = OPD_WIDTH'(vol);
        opd_b = OPD_WIDTH'(tdens);
      end
      OP_VX: begin
        opd_a = vd;
        opd_b = OPD_WIDTH'(gx_mag);
      end
      OP_VY: begin
        opd_a = vd;
        opd_b = OPD_WIDTH'(gy_mag);
      end
      OP_FX: begin
        opd_a = sx_abs;
        opd_b = sx_abs;
      end
      OP_FY: begin
        opd_a = sy_abs;
        opd_b = sy_abs;
      end
      default: begin
        opd_a = '0;
        opd_b = '0;
      end
    endcase
  end

  saf_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (opd_a),
    .b      (opd_b),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.out_write) begin
      sum_x <= '0;
      sum_y <= '0;
      msq   <= '0;
    end else if (cmd.mul_wb) begin
      case (cmd.op)
        OP_MX, OP_VX: sum_x <= add_term(sum_x, nx, mul_res);
        OP_MY, OP_VY: sum_y <= add_term(sum_y, ny, mul_res);
        OP_SQY:       msq   <= add_sat(msq, add_sat(sq, mul_res));
        default:      msq   <= msq;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_wb) begin
      case (cmd.op)
        OP_MX:         tmag_x <= clamp_mag(nx, mul_res);
        OP_MY:         tmag_y <= clamp_mag(ny, mul_res);
        OP_SQX, OP_FX: sq     <= mul_res;
        OP_VD:         vd     <= mul_res[SUM_WIDTH-1:0];
        OP_FY:         den    <= add_sat(add_sat(sq, mul_res), msq);
        default:       sq     <= sq;
      endcase
    end
  end

  saf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({dens, {FRAC_BITS{1'b0}}}),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  assign is_zero = (den == '0);
  assign over    = |quo[DVD_WIDTH-1:WORD_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      denom_was_zero <= is_zero;
      saturated      <= !is_zero && over;
      if (is_zero) begin
        alpha <= '0;
      end else if (over) begin
        alpha <= {WORD_WIDTH{1'b1}};
      end else begin
        alpha <= quo[WORD_WIDTH-1:0];
      end
    end
  end

  assign status.mul_done = mul_done;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;
  assign status.last     = last;

endmodule

`default_nettype wire

// File: hdl/sph_alpha_factor.sv
// ----------------------------------------------------------------------------
// sph_alpha_factor: per-particle DFSPH alpha factor in Q16.16.
// Per item: no product for a neighbor with no contribution, three for a solid
// and four for a fluid neighbor, each on the shared 48x48 multiplier that
// takes 16-bit chunks. A last item adds two squares and a 47-step divide.
// Reset clears the sums and output valid and restores the config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sph_alpha_factor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [saf_pkg::IDX_WIDTH-1:0]     cfg_index,
  input  logic [saf_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // grad_x, grad_y, solid_volume, particle_density, zero pad
  input  logic [saf_pkg::IN_DATA_WIDTH-1:0] s_tdata,
  // mode
  input  logic [saf_pkg::MODE_WIDTH-1:0]    s_tuser,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // alpha
  output logic [saf_pkg::WORD_WIDTH-1:0]    m_tdata,
  // denom_was_zero, saturated
  output logic [saf_pkg::FLAG_WIDTH-1:0]    m_tuser
);
  import saf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       denom_was_zero;
  logic       saturated;

  assign cfg_ready = 1'b1;

  saf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  saf_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .grad_x           (s_tdata[GX_LSB +: WORD_WIDTH]),
    .grad_y           (s_tdata[GY_LSB +: WORD_WIDTH]),
    .solid_volume     (s_tdata[VOL_LSB +: CFG_WIDTH]),
    .particle_density (s_tdata[DENS_LSB +: CFG_WIDTH]),
    .last_neighbor    (s_tlast),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .alpha            (m_tdata),
    .denom_was_zero   (denom_was_zero),
    .saturated        (saturated)
  );

  assign m_tuser = {saturated, denom_was_zero};

endmodule

`default_nettype wire

// File: hdl/saf_checker.sv
// ----------------------------------------------------------------------------
// saf_checker
// Port-level checks of the alpha factor block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sph_alpha_factor_defines.svh"

module saf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [saf_pkg::WORD_WIDTH-1:0] m_tdata,
  input logic [saf_pkg::FLAG_WIDTH-1:0] m_tuser
);
  import saf_pkg::*;

  `SAF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `SAF_ASSERT(a_zero_result, m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1], "zero denominator result not clean")
  `SAF_ASSERT(a_sat_result, m_tvalid && m_tuser[1] |-> &m_tdata, "saturated result not clamped")
  `SAF_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind sph_alpha_factor saf_checker u_saf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
